/* sv/aprc_pkg.sv */
// ----------------------------------------------------------------------------
// aprc_pkg
// Types and constants shared by the addressed packet receiver and its checker,
// and the CRC-8 byte update used by the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package aprc_pkg;

  localparam int unsigned MaxPayload     = 32;
  localparam int unsigned PacketOverhead = 3;
  localparam logic [7:0]  Crc8Poly       = 8'h8C;
  localparam logic [3:0]  AddrMask       = 4'hF;

  localparam int unsigned AddrW  = 4;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned IdxW   = 6;
  localparam int unsigned StatW  = 3;
  localparam int unsigned PaddrW = 3;
  localparam int unsigned PdataW = 32;

  localparam int unsigned CntRawW = $clog2(MaxPayload + PacketOverhead + 1);
  localparam int unsigned CntW    = (CntRawW > IdxW) ? CntRawW : IdxW;
  localparam int unsigned CmpW    = ((CntW > ByteW) ? CntW : ByteW) + 1;

  localparam logic [AddrW-1:0] OwnAddrRst   = 4'd1;
  localparam logic [AddrW-1:0] BcastAddrRst = 4'd15;

  typedef enum logic [StatW-1:0] {
    ST_IGNORED   = 3'd0,
    ST_BUSY      = 3'd1,
    ST_OK        = 3'd2,
    ST_CRC_ERR   = 3'd3,
    ST_FRAME_ERR = 3'd4,
    ST_BYTE_OVR  = 3'd5,
    ST_BUF_OVR   = 3'd6
  } rx_status_e;

  typedef enum logic {
    REG_OWN_ADDR   = 1'b0,
    REG_BCAST_ADDR = 1'b1
  } reg_idx_e;

  typedef struct packed {
    rx_status_e       status;
    logic [IdxW-1:0]  index;
    logic [ByteW-1:0] sbyte;
    logic             stored;
  } rx_result_t;

  // Reflected Dallas CRC-8, one byte per call
  function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ Crc8Poly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* sv/addressed_packet_receiver_crc8.sv */
// ----------------------------------------------------------------------------
// addressed_packet_receiver_crc8
// Multidrop 9-bit UART packet receiver: address, length, payload, CRC-8.
// ----------------------------------------------------------------------------
// Every accepted UART byte yields exactly one result request. With the output
// not stalled it appears at out_valid_o in the cycle after acceptance; a byte
// taken while a result waits is held in the skid register until the result
// ahead of it leaves. A new byte is taken every cycle while in_stall_o is low:
// the CRC-8 byte update and the count/length compare are combinational on the
// byte at the input ports, and a two-entry output buffer (result register plus
// skid register) lets one more byte in while a result waits; in_stall_o rises
// only when both entries are full. Address registers are written through the
// APB port (own address at 0x0, broadcast address at 0x4).
`default_nettype none

module addressed_packet_receiver_crc8
  import aprc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,

  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [ByteW-1:0]  byte_value_i,
  input  wire logic              address_bit_i,
  input  wire logic              frame_error_i,
  input  wire logic              overrun_error_i,

  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [StatW-1:0]       rx_status_o,
  output logic [IdxW-1:0]        byte_index_o,
  output logic [ByteW-1:0]       stored_byte_o,
  output logic                   stored_o,

  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0]      prdata,
  output logic                   pready
);

  logic [AddrW-1:0] own_addr_q, bcast_addr_q;
  logic [CntW-1:0]  count_q, count_d;
  logic [7:0]       crc_q, crc_d;
  logic [ByteW-1:0] len_q, len_d;
  logic             aom_q, aom_d;

  logic             out_valid_q, skid_valid_q;
  rx_result_t       out_q, skid_q, res;

  logic             in_fire, out_take, cfg_wr;
  reg_idx_e         reg_idx;
  logic [7:0]       crc_next;
  logic [CntW-1:0]  cnt_inc;
  logic [ByteW-1:0] len_sel;
  logic [AddrW-1:0] nibble;
  logic             match;

  // configuration
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q   <= OwnAddrRst;
      bcast_addr_q <= BcastAddrRst;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_OWN_ADDR:   own_addr_q   <= pwdata[AddrW-1:0] & AddrMask;
        REG_BCAST_ADDR: bcast_addr_q <= pwdata[AddrW-1:0] & AddrMask;
        default:        ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_OWN_ADDR:   prdata = {{(PdataW-AddrW){1'b0}}, own_addr_q};
      REG_BCAST_ADDR: prdata = {{(PdataW-AddrW){1'b0}}, bcast_addr_q};
      default:        prdata = '0;
    endcase
  end

  // handshake
  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i && !skid_valid_q;
  assign out_take   = out_valid_q && !out_stall_i;

  // per-byte step
  assign crc_next = crc8_update(crc_q, byte_value_i);
  assign cnt_inc  = count_q + CntW'(1);
  assign len_sel  = (count_q == CntW'(1)) ? byte_value_i : len_q;
  assign nibble   = byte_value_i[AddrW-1:0] & AddrMask;
  assign match    = (nibble == own_addr_q) || (nibble == bcast_addr_q);

  always_comb begin
    res     = '{status: ST_IGNORED, index: '0, sbyte: '0, stored: 1'b0};
    count_d = count_q;
    crc_d   = crc_q;
    len_d   = len_q;
    aom_d   = aom_q;
    if (frame_error_i) begin
      res.status = ST_FRAME_ERR;
      count_d    = '0;
      crc_d      = '0;
    end else if (overrun_error_i) begin
      res.status = ST_BYTE_OVR;
      count_d    = '0;
      crc_d      = '0;
    end else if (aom_q && !address_bit_i) begin
      res.status = ST_IGNORED;
    end else if ((count_q != '0) || match) begin
      if (count_q == '0) begin
        aom_d = 1'b0;
      end
      res.stored = 1'b1;
      res.index  = count_q[IdxW-1:0];
      res.sbyte  = byte_value_i;
      len_d      = len_sel;
      crc_d      = crc_next;
      count_d    = cnt_inc;
      if ((count_q == CntW'(1)) && (byte_value_i > ByteW'(MaxPayload))) begin
        res.status = ST_BUF_OVR;
        count_d    = '0;
        crc_d      = '0;
      end else if (CmpW'(cnt_inc) >= (CmpW'(len_sel) + CmpW'(PacketOverhead))) begin
        res.status = (crc_q == byte_value_i) ? ST_OK : ST_CRC_ERR;
        aom_d      = 1'b1;
        count_d    = '0;
        crc_d      = '0;
      end else begin
        res.status = ST_BUSY;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      crc_q   <= '0;
      len_q   <= '0;
      aom_q   <= 1'b0;
    end else if (in_fire) begin
      count_q <= count_d;
      crc_q   <= crc_d;
      len_q   <= len_d;
      aom_q   <= aom_d;
    end
  end

  // two-entry output buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_take || !out_valid_q) begin
      out_valid_q  <= skid_valid_q || in_fire;
      skid_valid_q <= 1'b0;
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take || !out_valid_q) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (in_fire) begin
      skid_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign rx_status_o   = out_q.status;
  assign byte_index_o  = out_q.index;
  assign stored_byte_o = out_q.sbyte;
  assign stored_o      = out_q.stored;

endmodule

`default_nettype wire

/* sv/aprc_checker.sv */
// ----------------------------------------------------------------------------
// aprc_checker
// Port-level assertions for the addressed packet receiver, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module aprc_checker
  import aprc_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_stall_o,
  input wire logic             out_valid_o,
  input wire logic             out_stall_i,
  input wire logic [StatW-1:0] rx_status_o,
  input wire logic [IdxW-1:0]  byte_index_o,
  input wire logic [ByteW-1:0] stored_byte_o,
  input wire logic             stored_o
);

  // input side stalls only while a result is pending
  a_stall_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("in_stall_o without pending result");

  // a dropped byte reports zero index and data
  a_unstored_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !stored_o) |-> (byte_index_o == '0 && stored_byte_o == '0))
    else $error("unstored result carries data");

  // stored flag agrees with status
  a_stored_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !stored_o) |->
      (rx_status_o == ST_IGNORED || rx_status_o == ST_FRAME_ERR ||
       rx_status_o == ST_BYTE_OVR))
    else $error("status without stored byte");

  // buffer overrun only on the length byte
  a_bufovr_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && rx_status_o == ST_BUF_OVR) |->
      (stored_o && byte_index_o == IdxW'(1)))
    else $error("buffer overrun off the length byte");

  // a stalled result request holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(rx_status_o) && $stable(byte_index_o) &&
       $stable(stored_byte_o) && $stable(stored_o)))
    else $error("stalled result changed");

endmodule

bind addressed_packet_receiver_crc8 aprc_checker u_aprc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .rx_status_o   (rx_status_o),
  .byte_index_o  (byte_index_o),
  .stored_byte_o (stored_byte_o),
  .stored_o      (stored_o)
);

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the addressed packet receiver with CRC-8.
// A queue-fed driver sends UART bytes and a clocked monitor checks every
// result request against a scoreboard. The scoreboard is filled by a
// behavioral copy of the receiver: address match, length, Dallas CRC-8 and
// address-only mode. Directed corner bytes come first. Random packets and
// noise follow under six address settings and three back-pressure mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import aprc_pkg::*;

  localparam int ClkPeriod  = 10;
  localparam int QuietLimit = 2000;
  localparam int PhaseItems = 200;
  localparam int MaxReports = 10;

  typedef struct packed {
    logic [ByteW-1:0] value;
    logic             abit;
    logic             fe;
    logic             ovr;
  } uart_byte_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic              in_valid  = 1'b0;
  logic              out_stall = 1'b0;
  uart_byte_t        drv_item  = '0;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [PaddrW-1:0] paddr     = '0;
  logic [PdataW-1:0] pwdata    = '0;

  logic              in_stall_o;
  logic              out_valid_o;
  logic [StatW-1:0]  rx_status_o;
  logic [IdxW-1:0]   byte_index_o;
  logic [ByteW-1:0]  stored_byte_o;
  logic              stored_o;
  logic [PdataW-1:0] prdata;
  logic              pready;

  // Receiver model state
  int unsigned  pkt_count = 0;
  logic [7:0]   pkt_crc   = '0;
  logic [7:0]   pkt_len   = '0;
  logic         addr_only = 1'b0;
  logic [3:0]   own_addr_m   = OwnAddrRst;
  logic [3:0]   bcast_addr_m = BcastAddrRst;

  uart_byte_t   byte_q[$];
  rx_result_t   rx_expect_q[$];
  int unsigned  n_queued  = 0;
  int unsigned  n_checked = 0;
  int unsigned  fail_count = 0;
  int unsigned  status_hits [7];
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;
  int unsigned  quiet_cycles  = 0;
  rx_result_t   mon_got, mon_want;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  addressed_packet_receiver_crc8 dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall_o),
    .byte_value_i    (drv_item.value),
    .address_bit_i   (drv_item.abit),
    .frame_error_i   (drv_item.fe),
    .overrun_error_i (drv_item.ovr),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall),
    .rx_status_o     (rx_status_o),
    .byte_index_o    (byte_index_o),
    .stored_byte_o   (stored_byte_o),
    .stored_o        (stored_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Reflected CRC-8, poly 0x8C, one data bit per iteration
  function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] d);
    logic [7:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      c = (c[0] ^ d[i]) ? ((c >> 1) ^ Crc8Poly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic rx_result_t receive_byte(uart_byte_t b);
    rx_result_t  r;
    logic [7:0]  crc_prev;
    int unsigned pos;
    logic        take;
    r = '{ST_IGNORED, '0, '0, 1'b0};
    if (b.fe) begin
      r.status  = ST_FRAME_ERR;
      pkt_count = 0;
      pkt_crc   = '0;
    end else if (b.ovr) begin
      r.status  = ST_BYTE_OVR;
      pkt_count = 0;
      pkt_crc   = '0;
    end else if (!(addr_only && !b.abit)) begin
      take = 1'b1;
      if (pkt_count == 0) begin
        if (b.value[3:0] != own_addr_m && b.value[3:0] != bcast_addr_m) begin
          take = 1'b0;
        end else begin
          addr_only = 1'b0;
        end
      end
      if (take) begin
        crc_prev = pkt_crc;
        pos      = pkt_count;
        r.stored = 1'b1;
        r.index  = pos[IdxW-1:0];
        r.sbyte  = b.value;
        if (pos == 1) begin
          pkt_len = b.value;
        end
        pkt_crc   = crc8_step(pkt_crc, b.value);
        pkt_count = pkt_count + 1;
        if (pos == 1 && pkt_len > MaxPayload) begin
          r.status  = ST_BUF_OVR;
          pkt_count = 0;
          pkt_crc   = '0;
        end else if (pkt_count >= pkt_len + PacketOverhead) begin
          r.status  = (crc_prev == b.value) ? ST_OK : ST_CRC_ERR;
          addr_only = 1'b1;
          pkt_count = 0;
          pkt_crc   = '0;
        end else begin
          r.status = ST_BUSY;
        end
      end
    end
    status_hits[r.status] = status_hits[r.status] + 1;
    return r;
  endfunction

  task automatic report_mismatch(string what, rx_result_t want, rx_result_t got);
    fail_count = fail_count + 1;
    if (fail_count <= MaxReports) begin
      $display("%0t %s: exp status=%0d idx=%0d byte=%02h stored=%0b", $realtime, what,
               want.status, want.index, want.sbyte, want.stored);
      $display("%0t %s: got status=%0d idx=%0d byte=%02h stored=%0b", $realtime, what,
               got.status, got.index, got.sbyte, got.stored);
    end
  endtask

  // Driver: hold the request until accepted, then load the next one
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid || !in_stall_o) begin
        if (in_valid) begin
          rx_expect_q.push_back(receive_byte(drv_item));
        end
        if (byte_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_item <= byte_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall) begin
        mon_got = '{rx_status_e'(rx_status_o), byte_index_o, stored_byte_o, stored_o};
        if (rx_expect_q.size() == 0) begin
          report_mismatch("unexpected result", '0, mon_got);
        end else begin
          mon_want  = rx_expect_q.pop_front();
          n_checked = n_checked + 1;
          if (mon_got.status !== mon_want.status || mon_got.index !== mon_want.index ||
              mon_got.sbyte !== mon_want.sbyte || mon_got.stored !== mon_want.stored) begin
            report_mismatch("result mismatch", mon_want, mon_got);
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) || psel) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("watchdog: no request moved for %0d cycles", QuietLimit);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic write_reg(reg_idx_e idx, logic [3:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PaddrW'(4 * int'(idx));
    pwdata  <= {28'($urandom()), val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_OWN_ADDR) begin
      own_addr_m = val;
    end else begin
      bcast_addr_m = val;
    end
  endtask

  task automatic queue_byte(logic [7:0] v, logic a, logic fe, logic ovr);
    byte_q.push_back('{v, a, fe, ovr});
    n_queued = n_queued + 1;
  endtask

  task automatic queue_packet(logic [7:0] addr, logic [7:0] len, bit bad_crc, int err_pct);
    logic [7:0] crc;
    logic [7:0] pay;
    queue_byte(addr, 1'b1, $urandom_range(99) < err_pct, $urandom_range(99) < err_pct);
    queue_byte(len, 1'($urandom()), $urandom_range(99) < err_pct,
               $urandom_range(99) < err_pct);
    crc = crc8_step(crc8_step(8'h00, addr), len);
    if (len <= MaxPayload) begin
      for (int i = 0; i < int'(len); i++) begin
        pay = 8'($urandom());
        crc = crc8_step(crc, pay);
        queue_byte(pay, 1'($urandom()), $urandom_range(99) < err_pct,
                   $urandom_range(99) < err_pct);
      end
      if (bad_crc) begin
        crc = crc ^ 8'($urandom_range(255, 1));
      end
      queue_byte(crc, 1'($urandom()), $urandom_range(99) < err_pct,
                 $urandom_range(99) < err_pct);
    end
  endtask

  task automatic queue_random_traffic(int unsigned n_items);
    int unsigned start;
    int unsigned pick;
    logic [3:0]  nib;
    logic [7:0]  len;
    start = n_queued;
    while (n_queued - start < n_items) begin
      if ($urandom_range(99) < 75) begin
        pick = $urandom_range(99);
        nib  = (pick < 45) ? own_addr_m : (pick < 80) ? bcast_addr_m : 4'($urandom());
        pick = $urandom_range(99);
        if (pick < 60) len = 8'($urandom_range(4));
        else if (pick < 85) len = 8'($urandom_range(12, 5));
        else if (pick < 93) len = 8'($urandom_range(31, 13));
        else if (pick < 97) len = 8'(MaxPayload);
        else len = 8'($urandom_range(255, MaxPayload + 1));
        if ($urandom_range(99) < 5) begin
          queue_byte({4'($urandom()), nib}, 1'b0, 1'b0, 1'b0);
        end
        queue_packet({4'($urandom()), nib}, len, $urandom_range(99) < 20,
                     ($urandom_range(99) < 15) ? 4 : 0);
      end else begin
        repeat ($urandom_range(4, 1)) begin
          queue_byte(8'($urandom()), 1'($urandom()), $urandom_range(99) < 15,
                     $urandom_range(99) < 15);
        end
      end
    end
  endtask

  initial begin
    int phase;
    logic [3:0] own_v, bcast_v;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (phase = 0; phase < 6; phase++) begin
      if (phase > 0) begin
        while (n_checked != n_queued) @(posedge clk_i);
        repeat (3) @(posedge clk_i);
        case (phase)
          1: begin own_v = 4'd0;  bcast_v = 4'd15; end
          2: begin own_v = 4'd15; bcast_v = 4'd0;  end
          3: begin own_v = 4'd7;  bcast_v = 4'd7;  end
          default: begin own_v = 4'($urandom()); bcast_v = 4'($urandom()); end
        endcase
        write_reg(REG_OWN_ADDR, own_v);
        write_reg(REG_BCAST_ADDR, bcast_v);
      end
      case (phase / 2)
        0: begin send_idle_pct = 9;  recv_idle_pct = 48; end
        1: begin send_idle_pct = 48; recv_idle_pct = 9;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      if (phase == 0) begin
        // error flags, frame error wins over overrun
        queue_byte(8'h00, 1'b0, 1'b1, 1'b0);
        queue_byte(8'hFF, 1'b1, 1'b0, 1'b1);
        queue_byte(8'hA5, 1'b1, 1'b1, 1'b1);
        // address mismatch, then a packet to the own address
        queue_byte(8'h02, 1'b0, 1'b0, 1'b0);
        queue_packet(8'hF1, 8'd1, 1'b0, 0);
        // address-only mode: data dropped, wrong address dropped, then a broadcast packet
        queue_byte(8'h01, 1'b0, 1'b0, 1'b0);
        queue_byte(8'h32, 1'b1, 1'b0, 1'b0);
        queue_packet(8'h0F, 8'd0, 1'b1, 0);
        // length over limit
        queue_packet(8'h01, 8'(MaxPayload + 1), 1'b0, 0);
        queue_packet(8'h1F, 8'hFF, 1'b0, 0);
        // errors in the middle of a packet
        queue_byte(8'h01, 1'b1, 1'b0, 1'b0);
        queue_byte(8'h02, 1'b0, 1'b0, 1'b0);
        queue_byte(8'h5A, 1'b0, 1'b1, 1'b0);
        queue_byte(8'h00, 1'b1, 1'b0, 1'b1);
        queue_packet(8'h01, 8'd0, 1'b0, 0);
      end
      queue_random_traffic(PhaseItems);
    end
    while (n_checked != n_queued) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (rx_expect_q.size() != 0) begin
      fail_count = fail_count + 1;
      $display("%0d expected results never arrived", rx_expect_q.size());
    end
    $display("run: %0d bytes, 6 address settings, %0d good packets, %0d crc errors",
             n_queued, status_hits[ST_OK], status_hits[ST_CRC_ERR]);
    $display("run: %0d length overruns, %0d frame, %0d byte overruns, %0d ignored, %0d fails",
             status_hits[ST_BUF_OVR], status_hits[ST_FRAME_ERR], status_hits[ST_BYTE_OVR],
             status_hits[ST_IGNORED], fail_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
sv/aprc_pkg.sv
sv/addressed_packet_receiver_crc8.sv
sv/aprc_checker.sv
verif/tb_top.sv
